FILE: rtl/uptok_pkg.sv
`default_nettype none

package uptok_pkg;

	// lead byte boundaries and payload masks
	localparam logic [7:0] CONT_BASE = 8'h80;
	localparam logic [7:0] LEAD2_BASE = 8'hC0;
	localparam logic [7:0] LEAD3_BASE = 8'hE0;
	localparam logic [7:0] LEAD4_BASE = 8'hF0;
	localparam logic [7:0] LEAD2_MASK = 8'h1F;
	localparam logic [7:0] LEAD3_MASK = 8'h0F;
	localparam logic [7:0] LEAD4_MASK = 8'h07;
	localparam logic [7:0] CONT_MASK = 8'h3F;

	localparam int CP_W = 21;
	localparam int TBL_CP_W = 16;

	typedef logic [CP_W-1:0] code_point_t;
	typedef logic [7:0] token_id_t;

	typedef struct packed {
		logic      found;
		token_id_t id;
	} vocab_hit_t;

	// fixed symbol vocabulary: code point to token id
	function automatic vocab_hit_t vocab_lookup(input code_point_t cp);
		vocab_hit_t r;
		logic [TBL_CP_W-1:0] lo;
		r.found = 1'b1;
		r.id = '0;
		lo = cp[TBL_CP_W-1:0];
		case (lo)
			16'h005F: r.id = 8'd0;   16'h003B: r.id = 8'd1;   16'h003A: r.id = 8'd2;
			16'h002C: r.id = 8'd3;   16'h002E: r.id = 8'd4;   16'h0021: r.id = 8'd5;
			16'h003F: r.id = 8'd6;   16'h00A1: r.id = 8'd7;   16'h00BF: r.id = 8'd8;
			16'h2014: r.id = 8'd9;   16'h2026: r.id = 8'd10;  16'h0022: r.id = 8'd11;
			16'h00AB: r.id = 8'd12;  16'h00BB: r.id = 8'd13;  16'h201C: r.id = 8'd14;
			16'h201D: r.id = 8'd15;  16'h0020: r.id = 8'd16;
			16'h0041: r.id = 8'd17;  16'h0042: r.id = 8'd18;  16'h0043: r.id = 8'd19;
			16'h0044: r.id = 8'd20;  16'h0045: r.id = 8'd21;  16'h0046: r.id = 8'd22;
			16'h0047: r.id = 8'd23;  16'h0048: r.id = 8'd24;  16'h0049: r.id = 8'd25;
			16'h004A: r.id = 8'd26;  16'h004B: r.id = 8'd27;  16'h004C: r.id = 8'd28;
			16'h004D: r.id = 8'd29;  16'h004E: r.id = 8'd30;  16'h004F: r.id = 8'd31;
			16'h0050: r.id = 8'd32;  16'h0051: r.id = 8'd33;  16'h0052: r.id = 8'd34;
			16'h0053: r.id = 8'd35;  16'h0054: r.id = 8'd36;  16'h0055: r.id = 8'd37;
			16'h0056: r.id = 8'd38;  16'h0057: r.id = 8'd39;  16'h0058: r.id = 8'd40;
			16'h0059: r.id = 8'd41;  16'h005A: r.id = 8'd42;
			16'h0061: r.id = 8'd43;  16'h0062: r.id = 8'd44;  16'h0063: r.id = 8'd45;
			16'h0064: r.id = 8'd46;  16'h0065: r.id = 8'd47;  16'h0066: r.id = 8'd48;
			16'h0067: r.id = 8'd49;  16'h0068: r.id = 8'd50;  16'h0069: r.id = 8'd51;
			16'h006A: r.id = 8'd52;  16'h006B: r.id = 8'd53;  16'h006C: r.id = 8'd54;
			16'h006D: r.id = 8'd55;  16'h006E: r.id = 8'd56;  16'h006F: r.id = 8'd57;
			16'h0070: r.id = 8'd58;  16'h0071: r.id = 8'd59;  16'h0072: r.id = 8'd60;
			16'h0073: r.id = 8'd61;  16'h0074: r.id = 8'd62;  16'h0075: r.id = 8'd63;
			16'h0076: r.id = 8'd64;  16'h0077: r.id = 8'd65;  16'h0078: r.id = 8'd66;
			16'h0079: r.id = 8'd67;  16'h007A: r.id = 8'd68;
			16'h0251: r.id = 8'd69;  16'h0250: r.id = 8'd70;  16'h0252: r.id = 8'd71;
			16'h00E6: r.id = 8'd72;  16'h0253: r.id = 8'd73;  16'h0299: r.id = 8'd74;
			16'h03B2: r.id = 8'd75;  16'h0254: r.id = 8'd76;  16'h0255: r.id = 8'd77;
			16'h00E7: r.id = 8'd78;  16'h0257: r.id = 8'd79;  16'h0256: r.id = 8'd80;
			16'h00F0: r.id = 8'd81;  16'h02A4: r.id = 8'd82;  16'h0259: r.id = 8'd83;
			16'h0258: r.id = 8'd84;  16'h025A: r.id = 8'd85;  16'h025B: r.id = 8'd86;
			16'h025C: r.id = 8'd87;  16'h025D: r.id = 8'd88;  16'h025E: r.id = 8'd89;
			16'h025F: r.id = 8'd90;  16'h0284: r.id = 8'd91;  16'h0261: r.id = 8'd92;
			16'h0260: r.id = 8'd93;  16'h0262: r.id = 8'd94;  16'h029B: r.id = 8'd95;
			16'h0266: r.id = 8'd96;  16'h0267: r.id = 8'd97;  16'h0127: r.id = 8'd98;
			16'h0265: r.id = 8'd99;  16'h029C: r.id = 8'd100; 16'h0268: r.id = 8'd101;
			16'h026A: r.id = 8'd102; 16'h029D: r.id = 8'd103; 16'h026D: r.id = 8'd104;
			16'h026C: r.id = 8'd105; 16'h026B: r.id = 8'd106; 16'h026E: r.id = 8'd107;
			16'h029F: r.id = 8'd108; 16'h0271: r.id = 8'd109; 16'h026F: r.id = 8'd110;
			16'h0270: r.id = 8'd111; 16'h014B: r.id = 8'd112; 16'h0273: r.id = 8'd113;
			16'h0272: r.id = 8'd114; 16'h0274: r.id = 8'd115; 16'h00F8: r.id = 8'd116;
			16'h0275: r.id = 8'd117; 16'h0278: r.id = 8'd118; 16'h03B8: r.id = 8'd119;
			16'h0153: r.id = 8'd120; 16'h0276: r.id = 8'd121; 16'h0298: r.id = 8'd122;
			16'h0279: r.id = 8'd123; 16'h027A: r.id = 8'd124; 16'h027E: r.id = 8'd125;
			16'h027B: r.id = 8'd126; 16'h0280: r.id = 8'd127; 16'h0281: r.id = 8'd128;
			16'h027D: r.id = 8'd129; 16'h0282: r.id = 8'd130; 16'h0283: r.id = 8'd131;
			16'h0288: r.id = 8'd132; 16'h02A7: r.id = 8'd133; 16'h0289: r.id = 8'd134;
			16'h028A: r.id = 8'd135; 16'h028B: r.id = 8'd136; 16'h2C71: r.id = 8'd137;
			16'h028C: r.id = 8'd138; 16'h0263: r.id = 8'd139; 16'h0264: r.id = 8'd140;
			16'h028D: r.id = 8'd141; 16'h03C7: r.id = 8'd142; 16'h028E: r.id = 8'd143;
			16'h028F: r.id = 8'd144; 16'h0291: r.id = 8'd145; 16'h0290: r.id = 8'd146;
			16'h0292: r.id = 8'd147; 16'h0294: r.id = 8'd148; 16'h02A1: r.id = 8'd149;
			16'h0295: r.id = 8'd150; 16'h02A2: r.id = 8'd151; 16'h01C0: r.id = 8'd152;
			16'h01C1: r.id = 8'd153; 16'h01C2: r.id = 8'd154; 16'h01C3: r.id = 8'd155;
			16'h02C8: r.id = 8'd156; 16'h02CC: r.id = 8'd157; 16'h02D0: r.id = 8'd158;
			16'h02D1: r.id = 8'd159; 16'h02BC: r.id = 8'd160; 16'h02B4: r.id = 8'd161;
			16'h02B0: r.id = 8'd162; 16'h02B1: r.id = 8'd163; 16'h02B2: r.id = 8'd164;
			16'h02B7: r.id = 8'd165; 16'h02E0: r.id = 8'd166; 16'h02E4: r.id = 8'd167;
			16'h02DE: r.id = 8'd168; 16'h2193: r.id = 8'd169; 16'h2191: r.id = 8'd170;
			16'h2192: r.id = 8'd171; 16'h2197: r.id = 8'd172; 16'h2198: r.id = 8'd173;
			16'h0329: r.id = 8'd175; 16'h1D7B: r.id = 8'd177;
			default: r.found = 1'b0;
		endcase
		// table holds only code points below 0x10000
		if (cp[CP_W-1:TBL_CP_W] != '0) begin
			r.found = 1'b0;
			r.id = '0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/utf8_phoneme_tokenizer_core.sv
// UTF-8 phoneme tokenizer: takes one text byte per beat (end_of_text on the
// last byte of a string), rebuilds code points with a lenient decoder and
// maps each one found in the built-in 176-symbol vocabulary to its token id.
// Unknown code points are dropped; the final byte always yields one beat with
// text_done set (token_valid low if nothing was recognized). A new byte can
// be accepted every cycle while the result side keeps up; a result is
// built by the input register followed by one decode-and-match stage into
// the result register. Decoder state resets after each final byte.
`default_nettype none

module utf8_phoneme_tokenizer_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// byte channel
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_text,
	// result channel
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [7:0]      token_id,
	output logic            token_valid,
	output logic            text_done
);

	logic                     valid_s1;
	logic [7:0]               byte_s1;
	logic                     eot_s1;
	uptok_pkg::code_point_t   cp_q;
	logic [1:0]               rem_q;

	logic                     out_free;
	logic                     adv_s1;
	uptok_pkg::code_point_t   cp_shift;
	uptok_pkg::code_point_t   cp_next;
	logic [1:0]               rem_next;
	logic                     have;
	uptok_pkg::code_point_t   cp_done;
	uptok_pkg::vocab_hit_t    hit;
	logic                     emit;

	// handshake: stage 1 moves on when the result register can take it
	assign out_free   = !result_valid || !result_stall;
	assign adv_s1     = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	// lenient decode step
	assign cp_shift = {cp_q[uptok_pkg::CP_W-7:0], byte_s1[5:0]};

	always_comb begin
		cp_next  = cp_q;
		rem_next = rem_q;
		have     = 1'b0;
		cp_done  = '0;
		if (rem_q != 2'd0) begin
			rem_next = rem_q - 2'd1;
			cp_next  = cp_shift;
			if (rem_q == 2'd1) begin
				have    = 1'b1;
				cp_done = cp_shift;
				cp_next = '0;
			end
		end else if (byte_s1 < uptok_pkg::CONT_BASE) begin
			have    = 1'b1;
			cp_done = {{(uptok_pkg::CP_W-8){1'b0}}, byte_s1};
		end else if (byte_s1 < uptok_pkg::LEAD2_BASE) begin
			// stray continuation byte: nothing changes
		end else if (byte_s1 < uptok_pkg::LEAD3_BASE) begin
			cp_next  = {{(uptok_pkg::CP_W-8){1'b0}}, byte_s1 & uptok_pkg::LEAD2_MASK};
			rem_next = 2'd1;
		end else if (byte_s1 < uptok_pkg::LEAD4_BASE) begin
			cp_next  = {{(uptok_pkg::CP_W-8){1'b0}}, byte_s1 & uptok_pkg::LEAD3_MASK};
			rem_next = 2'd2;
		end else begin
			cp_next  = {{(uptok_pkg::CP_W-8){1'b0}}, byte_s1 & uptok_pkg::LEAD4_MASK};
			rem_next = 2'd3;
		end
		// sequence cut short by the end of the text
		if (eot_s1 && !have && rem_next != 2'd0) begin
			have    = 1'b1;
			cp_done = cp_next;
		end
	end

	// vocabulary match
	always_comb begin
		hit = uptok_pkg::vocab_lookup(cp_done);
		if (!have) begin
			hit.found = 1'b0;
			hit.id    = '0;
		end
	end

	assign emit = eot_s1 || hit.found;

	// decoder state, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q  <= '0;
			rem_q <= 2'd0;
		end else if (adv_s1) begin
			if (eot_s1) begin
				cp_q  <= '0;
				rem_q <= 2'd0;
			end else begin
				cp_q  <= cp_next;
				rem_q <= rem_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= adv_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			token_id    <= hit.id;
			token_valid <= hit.found;
			text_done   <= eot_s1;
		end
	end

endmodule

`default_nettype wire

FILE: verif/utf8_phoneme_tokenizer_checker.sv
module utf8_phoneme_tokenizer_checker (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	input  logic      byte_stall,
	input  logic [7:0] text_byte,
	input  logic      end_of_text,
	input  logic      result_valid,
	input  logic      result_stall,
	input  logic [7:0] token_id,
	input  logic      token_valid,
	input  logic      text_done,
	output int        errors,
	output int        pending,
	output int        bytes_seen,
	output int        texts_seen,
	output int        results_seen,
	output int        tokens_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_IDS = 178;
	// ids with no symbol behind them
	localparam int HOLE_ID_LO = 174;
	localparam int HOLE_ID_HI = 176;
	localparam int MAX_REPORTS = 10;

	// symbol code point per token id
	localparam logic [15:0] SYMBOL_CP [0:NUM_IDS-1] = '{
		16'h005F, 16'h003B, 16'h003A, 16'h002C, 16'h002E, 16'h0021, 16'h003F, 16'h00A1,
		16'h00BF, 16'h2014, 16'h2026, 16'h0022, 16'h00AB, 16'h00BB, 16'h201C, 16'h201D,
		16'h0020, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
		16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
		16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
		16'h0058, 16'h0059, 16'h005A, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065,
		16'h0066, 16'h0067, 16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D,
		16'h006E, 16'h006F, 16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075,
		16'h0076, 16'h0077, 16'h0078, 16'h0079, 16'h007A, 16'h0251, 16'h0250, 16'h0252,
		16'h00E6, 16'h0253, 16'h0299, 16'h03B2, 16'h0254, 16'h0255, 16'h00E7, 16'h0257,
		16'h0256, 16'h00F0, 16'h02A4, 16'h0259, 16'h0258, 16'h025A, 16'h025B, 16'h025C,
		16'h025D, 16'h025E, 16'h025F, 16'h0284, 16'h0261, 16'h0260, 16'h0262, 16'h029B,
		16'h0266, 16'h0267, 16'h0127, 16'h0265, 16'h029C, 16'h0268, 16'h026A, 16'h029D,
		16'h026D, 16'h026C, 16'h026B, 16'h026E, 16'h029F, 16'h0271, 16'h026F, 16'h0270,
		16'h014B, 16'h0273, 16'h0272, 16'h0274, 16'h00F8, 16'h0275, 16'h0278, 16'h03B8,
		16'h0153, 16'h0276, 16'h0298, 16'h0279, 16'h027A, 16'h027E, 16'h027B, 16'h0280,
		16'h0281, 16'h027D, 16'h0282, 16'h0283, 16'h0288, 16'h02A7, 16'h0289, 16'h028A,
		16'h028B, 16'h2C71, 16'h028C, 16'h0263, 16'h0264, 16'h028D, 16'h03C7, 16'h028E,
		16'h028F, 16'h0291, 16'h0290, 16'h0292, 16'h0294, 16'h02A1, 16'h0295, 16'h02A2,
		16'h01C0, 16'h01C1, 16'h01C2, 16'h01C3, 16'h02C8, 16'h02CC, 16'h02D0, 16'h02D1,
		16'h02BC, 16'h02B4, 16'h02B0, 16'h02B1, 16'h02B2, 16'h02B7, 16'h02E0, 16'h02E4,
		16'h02DE, 16'h2193, 16'h2191, 16'h2192, 16'h2197, 16'h2198, 16'h0000, 16'h0329,
		16'h0000, 16'h1D7B
	};

	typedef struct packed {
		uptok_pkg::token_id_t id;
		logic                 hit;
		logic                 last;
	} token_beat_t;

	// decoder mirror
	uptok_pkg::code_point_t cp_acc;
	logic [1:0]             cont_left;
	token_beat_t            expected_tokens[$];
	int                     n_err, n_bytes, n_texts, n_results, n_tokens;

	always @(posedge clk or negedge arst_n) begin : track
		uptok_pkg::code_point_t cp_done;
		logic                   have;
		logic                   hit;
		uptok_pkg::token_id_t   hit_id;
		token_beat_t            want;
		if (!arst_n) begin
			cp_acc = '0;
			cont_left = '0;
			expected_tokens.delete();
			n_err = 0;
			n_bytes = 0;
			n_texts = 0;
			n_results = 0;
			n_tokens = 0;
		end else begin
			// byte beat: step the decoder, queue what it yields
			if (byte_valid && !byte_stall) begin
				have = 1'b0;
				cp_done = '0;
				n_bytes++;
				if (cont_left != 0) begin
					cp_acc = {cp_acc[uptok_pkg::CP_W-7:0],
						6'(text_byte & uptok_pkg::CONT_MASK)};
					cont_left = cont_left - 2'd1;
					if (cont_left == 0) begin
						have = 1'b1;
						cp_done = cp_acc;
						cp_acc = '0;
					end
				end else if (text_byte < uptok_pkg::CONT_BASE) begin
					have = 1'b1;
					cp_done = uptok_pkg::code_point_t'(text_byte);
				end else if (text_byte < uptok_pkg::LEAD2_BASE) begin
					// stray continuation, dropped
				end else if (text_byte < uptok_pkg::LEAD3_BASE) begin
					cp_acc = uptok_pkg::code_point_t'(text_byte & uptok_pkg::LEAD2_MASK);
					cont_left = 2'd1;
				end else if (text_byte < uptok_pkg::LEAD4_BASE) begin
					cp_acc = uptok_pkg::code_point_t'(text_byte & uptok_pkg::LEAD3_MASK);
					cont_left = 2'd2;
				end else begin
					cp_acc = uptok_pkg::code_point_t'(text_byte & uptok_pkg::LEAD4_MASK);
					cont_left = 2'd3;
				end

				// end of text flushes a cut-short sequence and clears state
				if (end_of_text) begin
					if (!have && cont_left != 0) begin
						have = 1'b1;
						cp_done = cp_acc;
					end
					cp_acc = '0;
					cont_left = '0;
					n_texts++;
				end

				hit = 1'b0;
				hit_id = '0;
				if (have) begin
					for (int k = 0; k < NUM_IDS; k++) begin
						if (!hit && k != HOLE_ID_LO && k != HOLE_ID_HI &&
						    cp_done == uptok_pkg::code_point_t'(SYMBOL_CP[k])) begin
							hit = 1'b1;
							hit_id = uptok_pkg::token_id_t'(k);
						end
					end
				end
				if (hit || end_of_text) begin
					want = '{id: hit_id, hit: hit, last: end_of_text};
					expected_tokens = {expected_tokens, want};
				end
			end

			// result beat: compare with the oldest expectation
			if (result_valid && !result_stall) begin
				n_results++;
				if (token_valid === 1'b1)
					n_tokens++;
				if (expected_tokens.size() == 0) begin
					if (n_err < MAX_REPORTS)
						$display("%0t: unexpected token beat id=%0d valid=%0b done=%0b",
							$realtime, token_id, token_valid, text_done);
					n_err++;
				end else begin
					want = expected_tokens.pop_front();
					if (token_id !== want.id || token_valid !== want.hit ||
					    text_done !== want.last) begin
						if (n_err < MAX_REPORTS)
							$display("%0t: token mismatch: expected id=%0d valid=%0b done=%0b,",
								$realtime, want.id, want.hit, want.last,
								" got id=%0d valid=%0b done=%0b",
								token_id, token_valid, text_done);
						n_err++;
					end
				end
			end
		end
		errors <= n_err;
		pending <= expected_tokens.size();
		bytes_seen <= n_bytes;
		texts_seen <= n_texts;
		results_seen <= n_results;
		tokens_seen <= n_tokens;
	end

endmodule

FILE: verif/utf8_phoneme_tokenizer_core_tb.sv
module utf8_phoneme_tokenizer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] byte_q_t[$];

	localparam int RANDOM_BYTES = 1500;
	localparam int MAX_WAIT = 11;
	localparam int DRAIN_CYCLES = 8;

	// known symbols outside the dense ascii and ipa ranges
	localparam logic [20:0] EXTRA_CP [0:24] = '{
		21'h00A1, 21'h00BF, 21'h00AB, 21'h00BB, 21'h00E6, 21'h00E7, 21'h00F0,
		21'h00F8, 21'h0127, 21'h014B, 21'h0153, 21'h01C0, 21'h01C3, 21'h0329,
		21'h03B2, 21'h03B8, 21'h03C7, 21'h1D7B, 21'h2014, 21'h2026, 21'h201C,
		21'h201D, 21'h2191, 21'h2198, 21'h2C71
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	logic [7:0] text_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [7:0] token_id;
	logic       token_valid;
	logic       text_done;

	logic       quiet = 1'b0;
	int         stall_left = 0;
	int         bytes_sent = 0;

	int         chk_errors, chk_pending, chk_bytes, chk_texts, chk_results, chk_tokens;

	utf8_phoneme_tokenizer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.token_id     (token_id),
		.token_valid  (token_valid),
		.text_done    (text_done)
	);

	utf8_phoneme_tokenizer_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.token_id     (token_id),
		.token_valid  (token_valid),
		.text_done    (text_done),
		.errors       (chk_errors),
		.pending      (chk_pending),
		.bytes_seen   (chk_bytes),
		.texts_seen   (chk_texts),
		.results_seen (chk_results),
		.tokens_seen  (chk_tokens)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// idle cycles before a beat; none during quiet stretches
	function automatic int draw_wait();
		if (quiet)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// token side: stall for a drawn number of cycles after each beat
	always @(posedge clk) begin
		if (result_valid && !result_stall)
			stall_left = draw_wait();
		else if (stall_left != 0)
			stall_left = stall_left - 1;
		result_stall <= (stall_left != 0);
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= last;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input byte_q_t txt);
		foreach (txt[i])
			send_byte(txt[i], i == txt.size() - 1);
	endtask

	// continuation byte, sometimes with a malformed top pair
	function automatic logic [7:0] cont_byte(input logic [5:0] bits);
		if ($urandom_range(0, 7) == 0)
			return {2'($urandom_range(0, 3)), bits};
		return {2'b10, bits};
	endfunction

	// one symbol worth of bytes: mostly known code points, some noise
	function automatic byte_q_t random_symbol();
		byte_q_t     q;
		logic [20:0] cp;
		int          pick;
		pick = $urandom_range(0, 19);
		if (pick < 2) begin
			q = {q, 8'($urandom_range(0, 255))};
			return q;
		end
		if (pick < 8)
			cp = 21'($urandom_range(8'h20, 8'h7F));
		else if (pick < 14)
			cp = 21'($urandom_range(16'h0250, 16'h02AF));
		else if (pick < 16)
			cp = 21'($urandom_range(16'h02B0, 16'h02E4));
		else if (pick < 18)
			cp = EXTRA_CP[$urandom_range(0, 24)];
		else if ($urandom_range(0, 1) == 0)
			cp = 21'($urandom_range(0, 16'hFFFF));
		else
			cp = 21'($urandom_range(0, 21'h1FFFFF));

		if (cp < 21'h80) begin
			q = {q, cp[7:0]};
		end else if (cp < 21'h800) begin
			q = {q, {3'b110, cp[10:6]}};
			q = {q, cont_byte(cp[5:0])};
		end else if (cp < 21'h10000) begin
			q = {q, {4'b1110, cp[15:12]}};
			q = {q, cont_byte(cp[11:6])};
			q = {q, cont_byte(cp[5:0])};
		end else begin
			// leads 0xf8 and up still open a four-byte sequence
			q = {q, {4'b1111, 1'($urandom_range(0, 3) == 0), cp[20:18]}};
			q = {q, cont_byte(cp[17:12])};
			q = {q, cont_byte(cp[11:6])};
			q = {q, cont_byte(cp[5:0])};
		end
		return q;
	endfunction

	initial begin
		byte_q_t txt;
		byte_q_t sym;
		int      n_sym;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ascii extremes, stray continuations, lax continuation, 3-byte symbol at end
		txt = {8'h61, 8'h00, 8'h7F, 8'h5F, 8'h80, 8'hBF, 8'hC9, 8'h91, 8'hC9, 8'h11,
		       8'hE1, 8'hB5, 8'hBB};
		send_text(txt);
		// unknown 4-byte, 0xff lead, stray continuation as final byte
		txt = {8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80};
		send_text(txt);
		// sequence cut short that lands on a known symbol
		txt = {8'hF0, 8'h80, 8'hA1};
		send_text(txt);

		// random texts, some ending mid-sequence
		while (bytes_sent < RANDOM_BYTES) begin
			quiet <= ($urandom_range(0, 5) == 0);
			txt.delete();
			n_sym = $urandom_range(1, 12);
			repeat (n_sym) begin
				sym = random_symbol();
				txt = {txt, sym};
			end
			if (sym.size() > 1 && $urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, sym.size() - 1))
					txt = txt[0:$-1];
			send_text(txt);
		end
		byte_valid <= 1'b0;

		// drain
		while (chk_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d bytes in %0d texts decoded;", chk_bytes, chk_texts,
			" %0d token beats compared, %0d with a symbol", chk_results, chk_tokens);
		if (chk_errors == 0 && chk_pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("timeout with %0d token beats outstanding", chk_pending);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/uptok_pkg.sv
rtl/utf8_phoneme_tokenizer_core.sv
verif/utf8_phoneme_tokenizer_checker.sv
verif/utf8_phoneme_tokenizer_core_tb.sv
